>>> src/opgc_pkg.sv
// Package with widths, constants and the arctangent table for the goal check.
package opgc_pkg;

  localparam int AngleSteps = 16;
  localparam int CordW = 36;
  localparam int AngW = 35;

  localparam logic signed [AngW-1:0] PiQ30 = 35'sd3373259426;
  localparam logic signed [AngW-1:0] HalfPiQ30 = 35'sd1686629713;
  localparam logic signed [AngW:0] TwoPiQ30 = 36'sd6746518852;
  localparam logic signed [CordW-1:0] CordicStart = 36'sd652032874;

  localparam logic [1:0] CfgFrontOffset = 2'd0;
  localparam logic [1:0] CfgPosTol = 2'd1;
  localparam logic [1:0] CfgHeadTol = 2'd2;

  typedef logic signed [CordW-1:0] cord_t;
  typedef logic signed [AngW-1:0] ang_t;

  function automatic ang_t atan_entry(input int i);
    logic [31:0] tab [30];
    tab = '{32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
            32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
            32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
            32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
            32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
            32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002};
    return ang_t'({3'b000, tab[i]});
  endfunction

endpackage

>>> src/opgc_vec.sv
// One vectoring CORDIC stage: rotates toward the x axis and accumulates angle.
module opgc_vec (
  input  logic clk,
  input  opgc_pkg::cord_t x_in,
  input  opgc_pkg::cord_t y_in,
  input  opgc_pkg::ang_t z_in,
  input  logic [4:0] step,
  output opgc_pkg::cord_t x_out,
  output opgc_pkg::cord_t y_out,
  output opgc_pkg::ang_t z_out
);
  import opgc_pkg::*;
  cord_t xs, ys;
  assign xs = x_in >>> step;
  assign ys = y_in >>> step;
  always_ff @(posedge clk) begin
    if (!y_in[CordW-1]) begin
      x_out <= x_in + ys;
      y_out <= y_in - xs;
      z_out <= z_in + atan_entry(int'(step));
    end else begin
      x_out <= x_in - ys;
      y_out <= y_in + xs;
      z_out <= z_in - atan_entry(int'(step));
    end
  end
endmodule

>>> src/opgc_rot.sv
// One rotation CORDIC stage: turns the vector by the sign of the residual angle.
module opgc_rot (
  input  logic clk,
  input  opgc_pkg::cord_t x_in,
  input  opgc_pkg::cord_t y_in,
  input  opgc_pkg::ang_t z_in,
  input  logic [4:0] step,
  output opgc_pkg::cord_t x_out,
  output opgc_pkg::cord_t y_out,
  output opgc_pkg::ang_t z_out
);
  import opgc_pkg::*;
  cord_t xs, ys;
  assign xs = x_in >>> step;
  assign ys = y_in >>> step;
  always_ff @(posedge clk) begin
    if (!z_in[AngW-1]) begin
      x_out <= x_in - ys;
      y_out <= y_in + xs;
      z_out <= z_in - atan_entry(int'(step));
    end else begin
      x_out <= x_in + ys;
      y_out <= y_in - xs;
      z_out <= z_in + atan_entry(int'(step));
    end
  end
endmodule

>>> src/offset_pose_goal_check.sv
// Top level of the offset-point goal check pipeline.
// Throughput: one word per cycle; busy is never asserted, every stage is a register.
// The two CORDIC chains set the latency, one shift-add stage per iteration.
// Reset clears the valid bits and loads the tolerance registers with their defaults.
// The receiver cannot stall: goal_reached is valid only in the cycle done is high.
module offset_pose_goal_check (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [23:0] cfg_data,
  input  logic signed [31:0] query_x,
  input  logic signed [31:0] query_y,
  input  logic signed [15:0] query_qx,
  input  logic signed [15:0] query_qy,
  input  logic signed [15:0] query_qz,
  input  logic signed [15:0] query_qw,
  input  logic signed [31:0] goal_x,
  input  logic signed [31:0] goal_y,
  input  logic signed [15:0] goal_qx,
  input  logic signed [15:0] goal_qy,
  input  logic signed [15:0] goal_qz,
  input  logic signed [15:0] goal_qw,
  output logic done,
  output logic goal_reached
);
  import opgc_pkg::*;

  localparam int NS = AngleSteps;
  localparam int Lat = 2 + NS + 1 + NS + 5;
  localparam int P0 = 2 + NS + 1 + NS;

  logic signed [23:0] fwd_offset;
  logic [22:0] position_tolerance;
  logic [14:0] heading_tolerance;

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_offset <= 24'sd327680;
      position_tolerance <= 23'd98304;
      heading_tolerance <= 15'd2048;
    end else if (cfg_we) begin
      case (cfg_index)
        CfgFrontOffset: fwd_offset <= cfg_data;
        CfgPosTol: position_tolerance <= cfg_data[22:0];
        CfgHeadTol: heading_tolerance <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic [Lat-1:0] vld;
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else vld <= {vld[Lat-2:0], start};
  end

  // Position words ride along the pipeline as a delay line.
  logic signed [31:0] px [P0+1], py [P0+1], gxd [P0+1], gyd [P0+1];
  always_ff @(posedge clk) begin
    px[0] <= query_x; py[0] <= query_y; gxd[0] <= goal_x; gyd[0] <= goal_y;
    for (int i = 1; i <= P0; i++) begin
      px[i] <= px[i-1]; py[i] <= py[i-1]; gxd[i] <= gxd[i-1]; gyd[i] <= gyd[i-1];
    end
  end

  // Stage 1: quaternion products.
  logic signed [31:0] q_wz, q_xy, q_yy, q_zz, g_wz, g_xy, g_yy, g_zz;
  always_ff @(posedge clk) begin
    q_wz <= query_qw * query_qz; q_xy <= query_qx * query_qy;
    q_yy <= query_qy * query_qy; q_zz <= query_qz * query_qz;
    g_wz <= goal_qw * goal_qz; g_xy <= goal_qx * goal_qy;
    g_yy <= goal_qy * goal_qy; g_zz <= goal_qz * goal_qz;
  end

  // Stage 2: atan2 arguments and quadrant pre-rotation.
  cord_t qsn, qcs, gsn, gcs;
  assign qsn = (cord_t'(q_wz) + cord_t'(q_xy)) <<< 1;
  assign qcs = (cord_t'(1) <<< 30) - ((cord_t'(q_yy) + cord_t'(q_zz)) <<< 1);
  assign gsn = (cord_t'(g_wz) + cord_t'(g_xy)) <<< 1;
  assign gcs = (cord_t'(1) <<< 30) - ((cord_t'(g_yy) + cord_t'(g_zz)) <<< 1);

  cord_t vqx [NS+1], vqy [NS+1], vgx [NS+1], vgy [NS+1];
  ang_t vqz [NS+1], vgz [NS+1];
  logic [NS:0] qzero, gzero;

  always_ff @(posedge clk) begin
    qzero[0] <= (qsn == '0) && (qcs == '0);
    gzero[0] <= (gsn == '0) && (gcs == '0);
    if (qcs[CordW-1]) begin
      if (!qsn[CordW-1]) begin
        vqx[0] <= qsn; vqy[0] <= -qcs; vqz[0] <= HalfPiQ30;
      end else begin
        vqx[0] <= -qsn; vqy[0] <= qcs; vqz[0] <= -HalfPiQ30;
      end
    end else begin
      vqx[0] <= qcs; vqy[0] <= qsn; vqz[0] <= '0;
    end
    if (gcs[CordW-1]) begin
      if (!gsn[CordW-1]) begin
        vgx[0] <= gsn; vgy[0] <= -gcs; vgz[0] <= HalfPiQ30;
      end else begin
        vgx[0] <= -gsn; vgy[0] <= gcs; vgz[0] <= -HalfPiQ30;
      end
    end else begin
      vgx[0] <= gcs; vgy[0] <= gsn; vgz[0] <= '0;
    end
    for (int i = 1; i <= NS; i++) begin
      qzero[i] <= qzero[i-1];
      gzero[i] <= gzero[i-1];
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_vec
    opgc_vec u_q (.clk, .x_in(vqx[i]), .y_in(vqy[i]), .z_in(vqz[i]), .step(5'(i)),
                  .x_out(vqx[i+1]), .y_out(vqy[i+1]), .z_out(vqz[i+1]));
    opgc_vec u_g (.clk, .x_in(vgx[i]), .y_in(vgy[i]), .z_in(vgz[i]), .step(5'(i)),
                  .x_out(vgx[i+1]), .y_out(vgy[i+1]), .z_out(vgz[i+1]));
  end

  ang_t qyaw, gyaw;
  assign qyaw = qzero[NS] ? '0 : vqz[NS];
  assign gyaw = gzero[NS] ? '0 : vgz[NS];

  // Yaw error, wrapped and rounded to Q6.13, then delayed to the final stage.
  // The wrap is registered before the magnitude and rounding.
  logic signed [AngW:0] dyaw, dwrap, dwrap_r;
  logic [AngW:0] dmag;
  logic [AngW-17:0] yerr;
  logic yaw_ok [NS+4];
  assign dyaw = (AngW+1)'(gyaw) - (AngW+1)'(qyaw);
  always_comb begin
    dwrap = dyaw;
    if (dyaw > (AngW+1)'(PiQ30)) dwrap = dyaw - TwoPiQ30;
    else if (dyaw < -((AngW+1)'(PiQ30))) dwrap = dyaw + TwoPiQ30;
  end
  always_ff @(posedge clk) dwrap_r <= dwrap;
  assign dmag = dwrap_r[AngW] ? -dwrap_r : dwrap_r;
  assign yerr = (AngW-16)'((dmag + (AngW+1)'(65536)) >> 17);
  always_ff @(posedge clk) begin
    yaw_ok[0] <= yerr <= (AngW-16)'(heading_tolerance);
    for (int i = 1; i < NS + 4; i++) yaw_ok[i] <= yaw_ok[i-1];
  end

  // Pre-rotation by pi for the cos/sin chain.
  cord_t rx [NS+1], ry [NS+1];
  ang_t rz [NS+1];
  logic [NS:0] rneg;
  always_ff @(posedge clk) begin
    rx[0] <= CordicStart; ry[0] <= '0;
    if (qyaw > HalfPiQ30) begin
      rz[0] <= qyaw - PiQ30; rneg[0] <= 1'b1;
    end else if (qyaw < -HalfPiQ30) begin
      rz[0] <= qyaw + PiQ30; rneg[0] <= 1'b1;
    end else begin
      rz[0] <= qyaw; rneg[0] <= 1'b0;
    end
    for (int i = 1; i <= NS; i++) rneg[i] <= rneg[i-1];
  end

  for (genvar i = 0; i < NS; i++) begin : g_rot
    opgc_rot u_r (.clk, .x_in(rx[i]), .y_in(ry[i]), .z_in(rz[i]), .step(5'(i)),
                  .x_out(rx[i+1]), .y_out(ry[i+1]), .z_out(rz[i+1]));
  end

  // Offset stage A: signed cos/sin, 24 x ~32 bit products.
  logic signed [CordW-1:0] cc, ss;
  assign cc = rneg[NS] ? -rx[NS] : rx[NS];
  assign ss = rneg[NS] ? -ry[NS] : ry[NS];
  logic signed [59:0] oc, os;
  always_ff @(posedge clk) begin
    oc <= 60'(fwd_offset) * 60'(cc);
    os <= 60'(fwd_offset) * 60'(ss);
  end

  // Offset stage B: position difference, absolute values.
  logic signed [34:0] dx, dy;
  logic [33:0] adx, ady;
  assign dx = 35'(px[P0]) + 35'(oc >>> 30) - 35'(gxd[P0]);
  assign dy = 35'(py[P0]) + 35'(os >>> 30) - 35'(gyd[P0]);
  always_ff @(posedge clk) begin
    adx <= 34'(dx[34] ? -dx : dx);
    ady <= 34'(dy[34] ? -dy : dy);
  end

  // Stage C: range gate and squares (operands fit in 23 bits when in range).
  logic near;
  logic [45:0] sqx, sqy, sqt;
  always_ff @(posedge clk) begin
    near <= (adx <= 34'(position_tolerance)) && (ady <= 34'(position_tolerance));
    sqx <= 46'(adx[22:0]) * 46'(adx[22:0]);
    sqy <= 46'(ady[22:0]) * 46'(ady[22:0]);
    sqt <= 46'(position_tolerance) * 46'(position_tolerance);
  end

  // Stage D: compare.
  logic pos_ok;
  always_ff @(posedge clk) pos_ok <= near && ((47'(sqx) + 47'(sqy)) <= 47'(sqt));

  // Stage E: result.
  always_ff @(posedge clk) goal_reached <= pos_ok && yaw_ok[NS+3];
  assign done = vld[Lat-1];

endmodule
